// ----- sv/block_rms_level_db_meter_top_defines.svh -----
// ----------------------------------------------------------------------------
// RMS level meter assertion macros
// Concurrent checks that are compiled for simulation only.
// ----------------------------------------------------------------------------
`ifndef BLOCK_RMS_LEVEL_DB_METER_TOP_DEFINES_SVH
`define BLOCK_RMS_LEVEL_DB_METER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BRMS_ASSERT_IMPL(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("brms: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BRMS_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("brms: next-cycle check failed");

`else

`define BRMS_ASSERT_IMPL(name, clk, rst, pre, post)
`define BRMS_ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

// ----- sv/brms_pkg.sv -----
// ----------------------------------------------------------------------------
// RMS level meter package
// Payload types, state encodings and fixed constants shared by the meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brms_pkg;

   // Field types of one input sample and one block result.
   typedef logic signed [15:0] sample_type;
   typedef logic signed [16:0] level_type;
   typedef logic [12:0]        sib_type;

   // Sum of squares in Q12.30 and a base-2 logarithm in Q6.16.
   typedef logic [41:0] sum_type;
   typedef logic [21:0] log_type;

   typedef struct packed {
      sample_type sample;
      logic       last_sample;
   } req_type;

   typedef struct packed {
      level_type level_db;
      sib_type   samples_in_block;
   } rsp_type;

   // Block queue between the accumulator and the level calculation.
   localparam int BQ_DEPTH = 4;
   localparam int BQ_AW    = 2;

   // 10*log10(2) in Q.16, and the Q12.30 scaling of the sum in Q.16.
   localparam logic [17:0] DB_PER_LOG2_Q16 = 18'd197283;
   localparam logic [22:0] LOG_OFFSET      = 23'd1966080;
   localparam logic [41:0] ROUND_HALF      = 42'd8388608;
   localparam logic [15:0] LEVEL_MAG_MAX   = 16'd51200;
   localparam level_type   LEVEL_FLOOR     = -17'sd51200;
   localparam level_type   LEVEL_TOP       = 17'sd0;

   typedef enum logic [1:0] {
      LG_IDLE,
      LG_NORM,
      LG_FRAC
   } lg_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOG_SUM,
      BK_LOG_CNT,
      BK_SCALE,
      BK_ROUND,
      BK_OUT
   } bk_state_type;

endpackage

// ----- sv/brms_front.sv -----
// ----------------------------------------------------------------------------
// RMS level meter front end
// Squares each sample, accumulates the saturating sum and count of a block
// and hands the finished block to the block queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brms_front #(
   parameter int MAX_BLOCK = 4096,
   parameter int CNT_W     = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  brms_pkg::req_type    req_data,
   input  logic                 q_full,
   output logic                 q_push,
   output brms_pkg::sum_type    q_sum,
   output logic [CNT_W-1:0]     q_count
);

   logic                s1_valid_ff, s1_valid_in;
   logic [30:0]         s1_sq_ff, s1_sq_in;
   logic                s1_last_ff, s1_last_in;
   brms_pkg::sum_type   sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic                s1_stall;
   logic                s1_go;
   logic                accept;
   logic [15:0]         raw;
   logic [15:0]         mag;
   logic [31:0]         sq;
   logic [42:0]         add;
   brms_pkg::sum_type   sum_acc;
   logic                room;
   brms_pkg::sum_type   sum_new;
   logic [CNT_W-1:0]    count_new;

   // Square stage: magnitude of the sample and its square.
   always_comb begin
      s1_stall = s1_valid_ff & s1_last_ff & q_full;
      full     = s1_stall;
      accept   = push & ~full;
      raw      = req_data.sample;
      mag      = raw[15] ? (~raw + 16'd1) : raw;
      sq       = 32'(mag) * 32'(mag);
      if (s1_stall) begin
         s1_valid_in = s1_valid_ff;
         s1_sq_in    = s1_sq_ff;
         s1_last_in  = s1_last_ff;
      end else begin
         s1_valid_in = accept;
         s1_sq_in    = sq[30:0];
         s1_last_in  = req_data.last_sample;
      end
   end

   // Accumulate stage: saturating add, count up to the block limit.
   always_comb begin
      s1_go     = s1_valid_ff & ~s1_stall;
      add       = {1'b0, sum_ff} + 43'(s1_sq_ff);
      sum_acc   = add[42] ? '1 : add[41:0];
      room      = count_ff < CNT_W'(MAX_BLOCK);
      sum_new   = room ? sum_acc : sum_ff;
      count_new = room ? (count_ff + CNT_W'(1)) : count_ff;
      q_push    = s1_go & s1_last_ff;
      q_sum     = sum_new;
      q_count   = count_new;
      sum_in    = sum_ff;
      count_in  = count_ff;
      if (s1_go) begin
         if (s1_last_ff) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_new;
            count_in = count_new;
         end
      end
   end

   // Control and accumulator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
      end
   end

   // Square stage payload.
   always_ff @(posedge clock) begin
      s1_sq_ff   <= s1_sq_in;
      s1_last_ff <= s1_last_in;
   end

endmodule

// ----- sv/brms_queue.sv -----
// ----------------------------------------------------------------------------
// RMS level meter block queue
// Holds finished block sums and counts until the back end takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brms_queue #(
   parameter int CNT_W = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  brms_pkg::sum_type    wr_sum,
   input  logic [CNT_W-1:0]     wr_count,
   output logic                 q_full,
   output logic                 q_empty,
   input  logic                 rd_en,
   output brms_pkg::sum_type    rd_sum,
   output logic [CNT_W-1:0]     rd_count
);

   brms_pkg::sum_type          sum_mem_ff [brms_pkg::BQ_DEPTH];
   logic [CNT_W-1:0]           cnt_mem_ff [brms_pkg::BQ_DEPTH];
   logic [brms_pkg::BQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [brms_pkg::BQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [brms_pkg::BQ_AW:0]   fill_ff, fill_in;
   logic                       do_wr;
   logic                       do_rd;

   // Pointer and fill bookkeeping.
   always_comb begin
      q_full    = fill_ff == (brms_pkg::BQ_AW + 1)'(brms_pkg::BQ_DEPTH);
      q_empty   = fill_ff == '0;
      do_wr     = wr_en & ~q_full;
      do_rd     = rd_en & ~q_empty;
      wr_ptr_in = do_wr ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - 1'b1;
      end
      rd_sum   = sum_mem_ff[rd_ptr_ff];
      rd_count = cnt_mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         sum_mem_ff[wr_ptr_ff] <= wr_sum;
         cnt_mem_ff[wr_ptr_ff] <= wr_count;
      end
   end

endmodule

// ----- sv/brms_log2.sv -----
// ----------------------------------------------------------------------------
// RMS level meter base-2 logarithm unit
// Normalises the operand a few bits per cycle, then finds sixteen fraction
// bits by repeated squaring, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brms_log2 (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  brms_pkg::sum_type    operand,
   output logic                 done,
   output brms_pkg::log_type    result
);

   brms_pkg::lg_state_type state_ff, state_in;
   brms_pkg::sum_type      w_ff, w_in;
   logic [5:0]             e_ff, e_in;
   logic [30:0]            m_ff, m_in;
   logic [15:0]            frac_ff, frac_in;
   logic [3:0]             step_ff, step_in;
   logic                   done_ff, done_in;
   logic [61:0]            prod;
   logic                   frac_bit;

   // Next state and datapath.
   always_comb begin
      state_in = state_ff;
      w_in     = w_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      prod     = 62'(m_ff) * 62'(m_ff);
      frac_bit = prod[61];
      case (state_ff)
         brms_pkg::LG_IDLE: begin
            if (start) begin
               if (operand == '0) begin
                  e_in    = '0;
                  frac_in = '0;
                  done_in = 1'b1;
               end else begin
                  w_in     = operand;
                  e_in     = 6'd41;
                  state_in = brms_pkg::LG_NORM;
               end
            end
         end
         brms_pkg::LG_NORM: begin
            // Bring the leading one to the top: eight places at once where
            // the top byte is clear, otherwise one.
            if (w_ff[41]) begin
               m_in     = w_ff[41:11];
               frac_in  = '0;
               step_in  = '0;
               state_in = brms_pkg::LG_FRAC;
            end else if (w_ff[41:34] == 8'd0) begin
               w_in = w_ff << 8;
               e_in = e_ff - 6'd8;
            end else begin
               w_in = w_ff << 1;
               e_in = e_ff - 6'd1;
            end
         end
         brms_pkg::LG_FRAC: begin
            // Square the mantissa; a result of two or more gives a one bit.
            m_in    = frac_bit ? prod[61:31] : prod[60:30];
            frac_in = {frac_ff[14:0], frac_bit};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               done_in  = 1'b1;
               state_in = brms_pkg::LG_IDLE;
            end
         end
         default: begin
            state_in = brms_pkg::LG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brms_pkg::LG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
   end

   assign done   = done_ff;
   assign result = {e_ff, frac_ff};

endmodule

// ----- sv/brms_back.sv -----
// ----------------------------------------------------------------------------
// RMS level meter back end
// Takes one finished block at a time, forms the level in dB from the two
// logarithms, or the floor for silence, and holds it in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brms_back #(
   parameter int CNT_W = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  brms_pkg::sum_type    q_sum,
   input  logic [CNT_W-1:0]     q_count,
   output logic                 q_pop,
   output logic                 lg_start,
   output brms_pkg::sum_type    lg_operand,
   input  logic                 lg_done,
   input  brms_pkg::log_type    lg_result,
   input  logic                 pop,
   output logic                 empty,
   output brms_pkg::rsp_type    rsp_data
);

   brms_pkg::bk_state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   brms_pkg::log_type      ls_ff, ls_in;
   logic [22:0]            neg_ff, neg_in;
   logic [40:0]            scale_ff, scale_in;
   brms_pkg::level_type    level_ff, level_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   brms_pkg::rsp_type      rsp_ff, rsp_in;

   logic [22:0]            lc;
   logic [22:0]            ls_ext;
   logic [41:0]            rnd;
   logic [17:0]            q_mag;
   logic [15:0]            q_clamp;

   // Sequencer for one block's level.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ls_in        = ls_ff;
      neg_in       = neg_ff;
      scale_in     = scale_ff;
      level_in     = level_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~pop;
      q_pop        = 1'b0;
      lg_start     = 1'b0;
      lg_operand   = q_sum;
      lc           = {1'b0, lg_result} + brms_pkg::LOG_OFFSET;
      ls_ext       = {1'b0, ls_ff};
      rnd          = {1'b0, scale_ff} + brms_pkg::ROUND_HALF;
      q_mag        = rnd[41:24];
      q_clamp      = (q_mag > 18'(brms_pkg::LEVEL_MAG_MAX)) ?
                     brms_pkg::LEVEL_MAG_MAX : q_mag[15:0];
      case (state_ff)
         brms_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               count_in = q_count;
               if (q_sum == '0) begin
                  // Silence reads as the floor.
                  level_in = brms_pkg::LEVEL_FLOOR;
                  state_in = brms_pkg::BK_OUT;
               end else begin
                  lg_start = 1'b1;
                  state_in = brms_pkg::BK_LOG_SUM;
               end
            end
         end
         brms_pkg::BK_LOG_SUM: begin
            if (lg_done) begin
               ls_in      = lg_result;
               lg_start   = 1'b1;
               lg_operand = brms_pkg::sum_type'(count_ff);
               state_in   = brms_pkg::BK_LOG_CNT;
            end
         end
         brms_pkg::BK_LOG_CNT: begin
            // A mean square of one or more is full scale.
            if (lg_done) begin
               if (ls_ext >= lc) begin
                  level_in = brms_pkg::LEVEL_TOP;
                  state_in = brms_pkg::BK_OUT;
               end else begin
                  neg_in   = lc - ls_ext;
                  state_in = brms_pkg::BK_SCALE;
               end
            end
         end
         brms_pkg::BK_SCALE: begin
            scale_in = 41'(neg_ff) * 41'(brms_pkg::DB_PER_LOG2_Q16);
            state_in = brms_pkg::BK_ROUND;
         end
         brms_pkg::BK_ROUND: begin
            level_in = brms_pkg::level_type'(17'sd0 - $signed({1'b0, q_clamp}));
            state_in = brms_pkg::BK_OUT;
         end
         brms_pkg::BK_OUT: begin
            if (!rsp_valid_ff || pop) begin
               rsp_valid_in             = 1'b1;
               rsp_in.level_db          = level_ff;
               rsp_in.samples_in_block  = brms_pkg::sib_type'(count_ff);
               state_in                 = brms_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = brms_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brms_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      ls_ff    <= ls_in;
      neg_ff   <= neg_in;
      scale_ff <= scale_in;
      level_ff <= level_in;
      rsp_ff   <= rsp_in;
   end

   assign empty    = ~rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ----- sv/block_rms_level_db_meter_top.sv -----
// ----------------------------------------------------------------------------
// Block RMS level meter, dBFS: samples are accepted one per clock while full
// is low; a block's level is formed from two iterative base-2 logarithms,
// which a silent block skips.
// Up to four finished blocks wait in the queue. Synchronous active-high reset
// clears all control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_rms_level_db_meter_top_defines.svh"

module block_rms_level_db_meter_top #(
   parameter int MAX_BLOCK = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  brms_pkg::req_type    req_data,
   output logic                 empty,
   input  logic                 pop,
   output brms_pkg::rsp_type    rsp_data
);

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);

   logic                q_push;
   brms_pkg::sum_type   q_in_sum;
   logic [CNT_W-1:0]    q_in_count;
   logic                q_full;
   logic                q_empty;
   logic                q_pop;
   brms_pkg::sum_type   q_out_sum;
   logic [CNT_W-1:0]    q_out_count;
   logic                lg_start;
   brms_pkg::sum_type   lg_operand;
   logic                lg_done;
   brms_pkg::log_type   lg_result;
   logic                level_in_range;

   // Accumulating front end.
   brms_front #(
      .MAX_BLOCK (MAX_BLOCK),
      .CNT_W     (CNT_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_sum    (q_in_sum),
      .q_count  (q_in_count)
   );

   // Finished blocks waiting for the level calculation.
   brms_queue #(
      .CNT_W (CNT_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_sum   (q_in_sum),
      .wr_count (q_in_count),
      .q_full   (q_full),
      .q_empty  (q_empty),
      .rd_en    (q_pop),
      .rd_sum   (q_out_sum),
      .rd_count (q_out_count)
   );

   // Shared logarithm unit.
   brms_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .start   (lg_start),
      .operand (lg_operand),
      .done    (lg_done),
      .result  (lg_result)
   );

   // Level calculation and result register.
   brms_back #(
      .CNT_W (CNT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_sum      (q_out_sum),
      .q_count    (q_out_count),
      .q_pop      (q_pop),
      .lg_start   (lg_start),
      .lg_operand (lg_operand),
      .lg_done    (lg_done),
      .lg_result  (lg_result),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data)
   );

   // The waiting level lies between the floor and full scale.
   assign level_in_range = (rsp_data.level_db <= brms_pkg::LEVEL_TOP) &&
                           (rsp_data.level_db >= brms_pkg::LEVEL_FLOOR);

   // A finished block is only handed over when the queue has room.
   `BRMS_ASSERT_IMPL(a_queue_push_room, clock, reset, q_push, !q_full)
   // The back end only takes a block that is waiting.
   `BRMS_ASSERT_IMPL(a_queue_pop_data, clock, reset, q_pop, !q_empty)
   // A logarithm is only started on a nonzero operand, so done never follows
   // its start at once.
   `BRMS_ASSERT_NEXT(a_log_start_done, clock, reset, lg_start, !lg_done)
   // A waiting result lies between the floor and full scale.
   `BRMS_ASSERT_IMPL(a_level_range, clock, reset, !empty, level_in_range)

endmodule
